// ----- src/u16u8_pkg.sv -----
// Shared types and constants for the UTF-16 to UTF-8 encoder with byte escapes.
// No dependencies; imported by every module in src.
`default_nettype none

package u16u8_pkg;

    // Depth of the job queue between the front and back parts
    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] REPL_RESET = 8'h3F;   // '?'

    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;   // 0xD800 >> 10
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;   // 0xDC00 >> 10
    localparam logic [20:0] SUPP_BASE     = 21'h010000;
    localparam logic [13:0] ESC_TAG       = 14'h21FC;    // 0x10FE00 >> 7
    localparam logic [20:0] ASCII_LIMIT   = 21'h000080;
    localparam logic [20:0] TWO_LIMIT     = 21'h000800;
    localparam logic [20:0] BMP_MAX       = 21'h00FFFF;
    localparam logic [20:0] NONCHAR_LO    = 21'h00FDD0;
    localparam logic [20:0] NONCHAR_HI    = 21'h00FDEF;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_name;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       name_end;
        logic       was_replaced;
    } out_t;

    // One input unit's worth of output bytes, byte 0 emitted first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            replaced;
        logic            eon;
    } job_t;

endpackage

`default_nettype wire

// ----- src/utf16_to_utf8_with_byte_escapes.sv -----
// Top level of the UTF-16 to UTF-8 encoder with raw-byte escapes.
// Depends on u16u8_pkg, u16u8_front, u16u8_fifo and u16u8_back.
//
// Takes one UTF-16 code unit per transaction on s_* and emits 0 to 4 UTF-8
// bytes, one per transaction on m_*. A high surrogate is held and emits
// nothing; with its low half it forms a code point. Code points
// U+10FE00..U+10FE7F leave as the single raw byte 0x80..0xFF. Lone
// surrogates, a high surrogate not followed by a low one (that unit is then
// dropped) and noncharacters at or above U+0800 give one replacement byte,
// flagged by was_replaced; the byte itself is set through cfg_wr_en /
// cfg_wr_data (reset '?'). end_of_name clears any pending high surrogate.
// last_of_run marks the final byte of each unit, name_end that byte when
// the unit closed a name. Rate: the output emits one byte per cycle while
// m_ready is high and jobs are queued; a unit makes 1 to 4 bytes, none for
// a held high surrogate. The input side takes one unit per cycle while the
// FIFO_DEPTH-entry job queue between the classifier and the byte sequencer
// has room; the first byte of an accepted unit goes through the job queue
// and then the output register before it is presented on m_*.
`default_nettype none

module utf16_to_utf8_with_byte_escapes #(
    parameter int FIFO_DEPTH = u16u8_pkg::FIFO_DEPTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    // configuration: replacement byte
    input  wire                 cfg_wr_en,
    input  wire [7:0]           cfg_wr_data,
    // code unit input
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire u16u8_pkg::in_t s_data,
    // byte output
    output logic                m_valid,
    input  wire                 m_ready,
    output u16u8_pkg::out_t     m_data
);
    import u16u8_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    job_t push_job, head_job;

    // classify units, track pending surrogate, build byte jobs
    u16u8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    // decouples the unit intake from byte emission
    u16u8_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    // one byte per cycle into the output register, unless m_ready stalls it
    u16u8_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// ----- src/u16u8_front.sv -----
// Front part: accepts code units, tracks the pending high surrogate and
// builds the byte job for each unit. Depends on u16u8_pkg.
`default_nettype none

module u16u8_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire [7:0]           cfg_wr_data,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire u16u8_pkg::in_t s_data,
    input  wire                 q_full,
    output logic                q_push,
    output u16u8_pkg::job_t     q_job
);
    import u16u8_pkg::*;

    logic [7:0]  repl_reg;
    logic        pend_reg, pend_next;
    logic [9:0]  high_reg, high_next;

    logic        accept, is_low, is_high, have_out, nonchar;
    logic [20:0] cp;
    logic [15:0] u;

    assign u       = s_data.code_unit;
    assign is_low  = (u[15:10] == SURR_LOW_TAG);
    assign is_high = (u[15:10] == SURR_HIGH_TAG);
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (pend_reg && is_low) begin
            cp = SUPP_BASE + {1'b0, high_reg, u[9:0]};
        end else begin
            cp = {5'd0, u};
        end
    end

    assign nonchar = ((cp >= NONCHAR_LO) && (cp <= NONCHAR_HI)) || (cp[15:1] == 15'h7FFF);

    always_comb begin
        q_job          = '0;
        q_job.eon      = s_data.end_of_name;
        have_out       = 1'b1;
        if (pend_reg ? !is_low : is_low) begin
            // lone low surrogate, or high surrogate without its low half
            q_job.bytes[0] = repl_reg;
            q_job.replaced = 1'b1;
        end else if (!pend_reg && is_high) begin
            have_out = 1'b0;
        end else if (cp[20:7] == ESC_TAG) begin
            q_job.bytes[0] = {1'b1, cp[6:0]};
        end else if (cp < ASCII_LIMIT) begin
            q_job.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp < TWO_LIMIT) begin
            q_job.bytes[0] = LEAD2 | {3'd0, cp[10:6]};
            q_job.bytes[1] = CONT | {2'd0, cp[5:0]};
            q_job.last_idx = 2'd1;
        end else if (nonchar) begin
            q_job.bytes[0] = repl_reg;
            q_job.replaced = 1'b1;
        end else if (cp > BMP_MAX) begin
            q_job.bytes[0] = LEAD4 | {5'd0, cp[20:18]};
            q_job.bytes[1] = CONT | {2'd0, cp[17:12]};
            q_job.bytes[2] = CONT | {2'd0, cp[11:6]};
            q_job.bytes[3] = CONT | {2'd0, cp[5:0]};
            q_job.last_idx = 2'd3;
        end else begin
            q_job.bytes[0] = LEAD3 | {4'd0, cp[15:12]};
            q_job.bytes[1] = CONT | {2'd0, cp[11:6]};
            q_job.bytes[2] = CONT | {2'd0, cp[5:0]};
            q_job.last_idx = 2'd2;
        end
    end

    assign q_push = accept && have_out;

    always_comb begin
        pend_next = pend_reg;
        high_next = high_reg;
        if (accept) begin
            if (pend_reg) begin
                pend_next = 1'b0;
            end else if (is_high) begin
                pend_next = 1'b1;
                high_next = u[9:0];
            end
            if (s_data.end_of_name) begin
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            high_reg <= '0;
            repl_reg <= REPL_RESET;
        end else begin
            pend_reg <= pend_next;
            high_reg <= high_next;
            if (cfg_wr_en) begin
                repl_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/u16u8_fifo.sv -----
// Small register queue of byte jobs between front and back parts.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_fifo #(
    parameter int DEPTH = u16u8_pkg::FIFO_DEPTH
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  wire u16u8_pkg::job_t push_job,
    output logic                 full,
    input  wire                  pop,
    output u16u8_pkg::job_t      head_job,
    output logic                 empty
);
    import u16u8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ----- src/u16u8_back.sv -----
// Back part: walks the head job byte by byte into a registered output.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire u16u8_pkg::job_t head_job,
    input  wire                  q_empty,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire                  m_ready,
    output u16u8_pkg::out_t      m_data
);
    import u16u8_pkg::*;

    logic       out_valid_reg, out_valid_next;
    out_t       out_data_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load, is_last;

    assign load    = !q_empty && (!out_valid_reg || m_ready);
    assign is_last = (idx_reg == head_job.last_idx);
    assign q_pop   = load && is_last;

    always_comb begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (load) begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg.out_byte     <= head_job.bytes[idx_reg];
            out_data_reg.last_of_run  <= is_last;
            out_data_reg.name_end     <= is_last && head_job.eon;
            out_data_reg.was_replaced <= head_job.replaced;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
